// ----- src/psrh_pkg.sv -----
// Package for the per-second rate history block.
// Item types, ring geometry and controller command/status structs; no dependencies.
package psrh_pkg;

  localparam int LIST_SIZE = 64;
  localparam int SLOT_W    = $clog2(LIST_SIZE);
  localparam int CNT_W     = $clog2(LIST_SIZE);
  localparam int RATE_W    = 31;
  localparam int SEC_W     = 32;
  localparam int AMT_W     = 16;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
  localparam logic [CNT_W-1:0]  N_MAX    = CNT_W'(LIST_SIZE - 1);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [SEC_W-1:0]  now_seconds;
    logic [AMT_W-1:0]  amount;
  } req_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [SEC_W-1:0]  second;
    logic [RATE_W-1:0] count;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_next;
    logic wr_en;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic add_go;
    logic query_go;
    logic last_pending;
    logic out_free;
  } sts_t;

endpackage

// ----- src/psrh_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module psrh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/psrh_ctrl.sv -----
// Controller for the rate history: sequences add read-modify-write and query streaming.
// Uses psrh_pkg command and status structs.
module psrh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  psrh_pkg::sts_t sts,
  output psrh_pkg::cmd_t cmd
);
  import psrh_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_QRY  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid && (sts.add_go || sts.query_go)) begin
          cmd.load   = 1'b1;
          cmd.rd_en  = 1'b1;
          state_next = sts.add_go ? S_ADD : S_QRY;
        end
      end
      S_ADD: begin
        cmd.wr_en  = 1'b1;
        state_next = S_IDLE;
      end
      S_QRY: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_pending) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/psrh_dp.sv -----
// Datapath for the rate history: slot RAM, valid bits, saturating add, query walk, output register.
// Uses psrh_pkg and psrh_ram.
module psrh_dp (
  input  logic           clk,
  input  logic           rst,
  input  psrh_pkg::req_t req,
  input  psrh_pkg::cmd_t cmd,
  output psrh_pkg::sts_t sts,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output psrh_pkg::rsp_t rsp
);
  import psrh_pkg::*;

  logic [SEC_W-1:0]     now_r;
  logic [AMT_W-1:0]     amt_r;
  logic [SEC_W-1:0]     sec_cur;
  logic [CNT_W-1:0]     remain;
  logic [CNT_W-1:0]     req_n;
  logic [SEC_W-1:0]     req_first;
  logic [SEC_W-1:0]     sec_inc;
  logic [LIST_SIZE-1:0] vld;
  logic                 rd_vld;
  logic [SLOT_W-1:0]    rd_addr;
  logic [SLOT_W-1:0]    wr_addr;
  logic [SLOT_BITS-1:0] rd_raw;
  slot_t                rd_slot;
  slot_t                wr_slot;
  logic [SEC_W-1:0]     sum;

  assign req_n     = (req.amount > AMT_W'(N_MAX)) ? N_MAX : req.amount[CNT_W-1:0];
  assign req_first = req.now_seconds - SEC_W'(req_n);
  assign sec_inc   = sec_cur + SEC_W'(1);

  assign sts.add_go       = (req.operation == OP_ADD) && (req.amount != '0);
  assign sts.query_go     = (req.operation == OP_QUERY) && (req.amount != '0);
  assign sts.last_pending = (remain == CNT_W'(1));
  assign sts.out_free     = !rsp_valid || rsp_ready;

  always_comb begin
    if (cmd.rd_next) begin
      rd_addr = sec_inc[SLOT_W-1:0];
    end else if (req.operation == OP_QUERY) begin
      rd_addr = req_first[SLOT_W-1:0];
    end else begin
      rd_addr = req.now_seconds[SLOT_W-1:0];
    end
  end

  assign wr_addr = now_r[SLOT_W-1:0];

  psrh_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (LIST_SIZE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_slot = rd_vld ? slot_t'(rd_raw) : '0;

  assign sum = {1'b0, rd_slot.count} + SEC_W'(amt_r);

  always_comb begin
    wr_slot.second = now_r;
    if (rd_slot.second == now_r) begin
      wr_slot.count = (sum > SEC_W'(RATE_MAX)) ? RATE_MAX : sum[RATE_W-1:0];
    end else begin
      wr_slot.count = RATE_W'(amt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_vld <= vld[rd_addr];
    end
    if (cmd.load) begin
      now_r   <= req.now_seconds;
      amt_r   <= req.amount;
      sec_cur <= req_first;
    end else if (cmd.rd_next) begin
      sec_cur <= sec_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (cmd.load) begin
      remain <= req_n;
    end else if (cmd.emit) begin
      remain <= remain - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.rate <= (rd_slot.second == sec_cur) ? rd_slot.count : '0;
      rsp.last <= sts.last_pending;
    end
  end

endmodule

// ----- src/per_second_rate_history.sv -----
// Per-second event rate history: a 64-slot ring of time-tagged counters.
// An add transfer (nonzero amount) does a slot read, then a saturating
// update written back; it returns nothing. A query transfer streams min(amount, 63)
// results, oldest second first, one per cycle while rsp_ready is high, and marks the
// final one with last; a stale slot reads as zero. The add reads before it writes, as the
// slot RAM has a single read port with a registered read. A new request is taken as soon as the last
// result of a query is in the output register. Top level; uses psrh_pkg, psrh_ctrl, psrh_dp.
module per_second_rate_history (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  psrh_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output psrh_pkg::rsp_t rsp
);
  import psrh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  psrh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  psrh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ----- test/per_second_rate_history_tb.sv -----
// Testbench for per_second_rate_history: random handshakes on both channels, checked
// against a scoreboard that mirrors the time-tagged 64-slot ring of per-second counts.
// Depends on psrh_pkg and the per_second_rate_history top level only.
module per_second_rate_history_tb;
  import psrh_pkg::*;

  class rate_ring_checker;
    logic [RATE_W-1:0] ring_count [LIST_SIZE];
    logic [SEC_W-1:0]  ring_tag   [LIST_SIZE];
    rsp_t              rates_due  [$];
    int                errors;

    function new();
      for (int i = 0; i < LIST_SIZE; i++) begin
        ring_count[i] = '0;
        ring_tag[i]   = '0;
      end
      errors = 0;
    endfunction

    function int pending();
      return rates_due.size();
    endfunction

    function void log_request(req_t r);
      int unsigned       k;
      int unsigned       n;
      logic [SEC_W-1:0]  sec;
      logic [SEC_W-1:0]  sum;
      rsp_t              e;
      if (r.operation == OP_ADD) begin
        if (r.amount == '0) return;
        k = r.now_seconds % LIST_SIZE;
        if (ring_tag[k] == r.now_seconds) begin
          sum = {1'b0, ring_count[k]} + SEC_W'(r.amount);
          ring_count[k] = sum[SEC_W-1] ? RATE_MAX : sum[RATE_W-1:0];
        end else begin
          ring_tag[k]   = r.now_seconds;
          ring_count[k] = RATE_W'(r.amount);
        end
      end else begin
        n = (r.amount > LIST_SIZE - 1) ? LIST_SIZE - 1 : r.amount;
        for (int unsigned j = 0; j < n; j++) begin
          sec    = r.now_seconds - SEC_W'(n) + SEC_W'(j);
          k      = sec % LIST_SIZE;
          e.rate = (ring_tag[k] == sec) ? ring_count[k] : '0;
          e.last = (j + 1 == n);
          rates_due = {rates_due, e};
        end
      end
    endfunction

    function void match_result(rsp_t got);
      rsp_t e;
      if (rates_due.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: unexpected transfer, expected none, actual rate %0d last %0d",
                   $time, got.rate, got.last);
        return;
      end
      e = rates_due.pop_front();
      if (got.rate !== e.rate || got.last !== e.last) begin
        errors++;
        if (errors <= 50)
          $display("%0t: mismatch, expected rate %0d last %0d, actual rate %0d last %0d",
                   $time, e.rate, e.last, got.rate, got.last);
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  rate_ring_checker ring = new();
  bit tx_idle_on = 1'b1;
  bit rx_stall_on = 1'b1;
  int rx_hold = 0;
  int sent = 0;

  per_second_rate_history u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) ring.log_request(req);
      if (rsp_valid && rsp_ready) ring.match_result(rsp);
    end
  end

  always @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      rx_hold = rx_stall_on ? $urandom_range(0, 17) : 0;
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    rsp_ready <= (rx_hold == 0);
  end

  task automatic send_item(logic op, logic [SEC_W-1:0] now, logic [AMT_W-1:0] amt);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{operation: op, now_seconds: now, amount: amt};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (!(op == OP_ADD && amt == '0)) sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (ring.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    logic [SEC_W-1:0] base;
    int               n_add;
    int               n_qry;
    logic [AMT_W-1:0] amt;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_item(OP_QUERY, 32'd10, 16'd5);
    send_item(OP_ADD, 32'd100, 16'd0);
    send_item(OP_ADD, 32'd100, 16'hFFFF);
    send_item(OP_ADD, 32'd100, 16'd1);
    send_item(OP_QUERY, 32'd101, 16'd1);
    send_item(OP_ADD, 32'd164, 16'd7);
    send_item(OP_QUERY, 32'd165, 16'd1);
    send_item(OP_QUERY, 32'd101, 16'd1);
    send_item(OP_QUERY, 32'd200, 16'd0);
    send_item(OP_ADD, 32'hFFFF_FFFF, 16'd3);
    send_item(OP_ADD, 32'hFFFF_FFFE, 16'd9);
    send_item(OP_ADD, 32'd0, 16'd2);
    send_item(OP_ADD, 32'd1, 16'd4);
    send_item(OP_QUERY, 32'd2, 16'd4);
    send_item(OP_QUERY, 32'd1, 16'hFFFF);
    send_item(OP_QUERY, 32'd70, 16'd64);
    send_item(OP_QUERY, 32'd70, 16'd63);
    send_item(OP_ADD, 32'h8000_0000, 16'h8000);
    send_item(OP_ADD, 32'h5555_5555, 16'h5555);
    send_item(OP_ADD, 32'hAAAA_AAAA, 16'hAAAA);
    send_item(OP_QUERY, 32'h8000_0001, 16'd2);
    send_item(OP_QUERY, 32'h5555_5556, 16'd1);
    send_item(OP_QUERY, 32'hAAAA_AAAB, 16'd2);
    wait_drained();

    // random episodes: adds around a base second, then queries looking back, or a single random request
    sent = 0;
    while (sent < 200) begin
      tx_idle_on  = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      base  = ($urandom_range(0, 4) == 0) ? SEC_W'($urandom_range(0, 40)) : $urandom;
      n_add = $urandom_range(1, 8);
      n_qry = $urandom_range(1, 2);
      if ($urandom_range(0, 5) == 0) begin
        send_item(logic'($urandom_range(0, 1)), $urandom, AMT_W'($urandom_range(0, 65535)));
      end else begin
        for (int i = 0; i < n_add; i++) begin
          case ($urandom_range(0, 9))
            0:       amt = '0;
            1:       amt = 16'hFFFF;
            2, 3:    amt = AMT_W'($urandom_range(0, 65535));
            default: amt = AMT_W'($urandom_range(1, 20));
          endcase
          send_item(OP_ADD, base - SEC_W'($urandom_range(0, 70)), amt);
        end
        for (int i = 0; i < n_qry; i++) begin
          amt = ($urandom_range(0, 7) == 0) ? AMT_W'($urandom_range(0, 65535))
                                            : AMT_W'($urandom_range(0, 70));
          send_item(OP_QUERY, base + SEC_W'($urandom_range(0, 3)), amt);
        end
      end
      if (sent >= 100 && sent < 110) wait_drained();
    end

    wait_drained();
    if (ring.errors == 0) begin
      $display("per_second_rate_history_tb passed");
    end else begin
      $display("per_second_rate_history_tb failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("per_second_rate_history_tb failed");
    $finish;
  end

endmodule
